/* rtl/mi3_pkg.sv */
`default_nettype none
package mi3_pkg;

	// threshold register
	localparam int TW = 32;
	localparam logic [TW-1:0] THR_RESET = 32'd281;

	// per-element flags that ride along the divider lanes
	typedef struct packed {
		logic zero;  // singular: force the element to zero
		logic neg;   // quotient sign
	} side_t;

endpackage
`default_nettype wire

/* rtl/mi3_mat_if.sv */
`default_nettype none
interface mi3_mat_if #(parameter int W = 32);
	logic valid;
	logic ready;
	logic signed [W-1:0] m_r0c0;
	logic signed [W-1:0] m_r0c1;
	logic signed [W-1:0] m_r0c2;
	logic signed [W-1:0] m_r1c0;
	logic signed [W-1:0] m_r1c1;
	logic signed [W-1:0] m_r1c2;
	logic signed [W-1:0] m_r2c0;
	logic signed [W-1:0] m_r2c1;
	logic signed [W-1:0] m_r2c2;

	modport source (
		output valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2, m_r2c0, m_r2c1, m_r2c2,
		input ready
	);
	modport sink (
		input valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2, m_r2c0, m_r2c1, m_r2c2,
		output ready
	);
endinterface
`default_nettype wire

/* rtl/mi3_inv_if.sv */
`default_nettype none
interface mi3_inv_if #(parameter int W = 32);
	logic valid;
	logic ready;
	logic signed [W-1:0] inv_r0c0;
	logic signed [W-1:0] inv_r0c1;
	logic signed [W-1:0] inv_r0c2;
	logic signed [W-1:0] inv_r1c0;
	logic signed [W-1:0] inv_r1c1;
	logic signed [W-1:0] inv_r1c2;
	logic signed [W-1:0] inv_r2c0;
	logic signed [W-1:0] inv_r2c1;
	logic signed [W-1:0] inv_r2c2;
	logic singular;

	modport source (
		output valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1, inv_r1c2,
		inv_r2c0, inv_r2c1, inv_r2c2, singular,
		input ready
	);
	modport sink (
		input valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1, inv_r1c2,
		inv_r2c0, inv_r2c1, inv_r2c2, singular,
		output ready
	);
endinterface
`default_nettype wire

/* rtl/mi3_cfg_if.sv */
`default_nettype none
interface mi3_cfg_if;
	logic valid;
	logic ready;
	logic [mi3_pkg::TW-1:0] singular_threshold;

	modport source (output valid, singular_threshold, input ready);
	modport sink (input valid, singular_threshold, output ready);
endinterface
`default_nettype wire

/* rtl/mi3_cof.sv */
`default_nettype none
// Stages 1-2: cofactors as cross products of row pairs
module mi3_cof #(
	parameter int W = 32
) (
	input  wire logic                clk,
	input  wire logic [1:0]          en,
	input  wire logic signed [W-1:0] m [9],
	output logic signed [2*W:0]      cof [9],
	output logic signed [W-1:0]      row0 [3]
);
	logic signed [2*W-1:0] pa_s1 [9];
	logic signed [2*W-1:0] pb_s1 [9];
	logic signed [W-1:0]   row0_s1 [3];
	logic signed [2*W:0]   cof_s2 [9];
	logic signed [W-1:0]   row0_s2 [3];

	// cof[i][k] = a[x]*b[y] - a[y]*b[x], a = row i+1, b = row i+2
	for (genvar i = 0; i < 3; i++) begin : g_row
		for (genvar k = 0; k < 3; k++) begin : g_col
			localparam int A = ((i + 1) % 3) * 3;
			localparam int B = ((i + 2) % 3) * 3;
			localparam int X = (k + 1) % 3;
			localparam int Y = (k + 2) % 3;
			always_ff @(posedge clk) begin
				if (en[0]) begin
					pa_s1[i*3+k] <= m[A+X] * m[B+Y];
					pb_s1[i*3+k] <= m[A+Y] * m[B+X];
				end
				if (en[1]) begin
					cof_s2[i*3+k] <= (2*W+1)'(pa_s1[i*3+k]) - (2*W+1)'(pb_s1[i*3+k]);
				end
			end
		end
	end

	// row 0 travels along for the determinant
	always_ff @(posedge clk) begin
		if (en[0]) begin
			row0_s1 <= '{m[0], m[1], m[2]};
		end
		if (en[1]) begin
			row0_s2 <= row0_s1;
		end
	end

	assign cof  = cof_s2;
	assign row0 = row0_s2;
endmodule
`default_nettype wire

/* rtl/mi3_det.sv */
`default_nettype none
// Stages 3-5: determinant = row0 . cofactor row 0, split multiplies
module mi3_det #(
	parameter int W = 32,
	parameter int D = 3*W+3
) (
	input  wire logic                clk,
	input  wire logic [2:0]          en,
	input  wire logic signed [2*W:0] cof_in [9],
	input  wire logic signed [W-1:0] row0 [3],
	output logic signed [D-1:0]      det,
	output logic signed [2*W:0]      cof [9]
);
	logic signed [2*W:0]   pl_s3 [3];
	logic signed [2*W:0]   ph_s3 [3];
	logic signed [3*W:0]   t_s4 [3];
	logic signed [D-1:0]   det_s5;
	logic signed [2*W:0]   cof_s3 [9];
	logic signed [2*W:0]   cof_s4 [9];
	logic signed [2*W:0]   cof_s5 [9];

	// partial products: low word unsigned, high part signed
	for (genvar j = 0; j < 3; j++) begin : g_pp
		logic signed [W:0] lo;
		logic signed [W:0] hi;
		assign lo = $signed({1'b0, cof_in[j][W-1:0]});
		assign hi = cof_in[j][2*W:W];
		always_ff @(posedge clk) begin
			if (en[0]) begin
				pl_s3[j] <= row0[j] * lo;
				ph_s3[j] <= row0[j] * hi;
			end
			if (en[1]) begin
				t_s4[j] <= ((3*W+1)'(ph_s3[j]) <<< W) + (3*W+1)'(pl_s3[j]);
			end
		end
	end

	// sum of the three terms, cofactors follow
	always_ff @(posedge clk) begin
		if (en[0]) begin
			cof_s3 <= cof_in;
		end
		if (en[1]) begin
			cof_s4 <= cof_s3;
		end
		if (en[2]) begin
			det_s5 <= D'(t_s4[0]) + D'(t_s4[1]) + D'(t_s4[2]);
			cof_s5 <= cof_s4;
		end
	end

	assign det = det_s5;
	assign cof = cof_s5;
endmodule
`default_nettype wire

/* rtl/mi3_prep.sv */
`default_nettype none
// Stages 6-7: magnitudes, signs, singular test, rounded numerators
module mi3_prep #(
	parameter int W  = 32,
	parameter int F  = 16,
	parameter int D  = 3*W+3,
	parameter int NW = 3*W+3
) (
	input  wire logic                    clk,
	input  wire logic [1:0]              en,
	input  wire logic signed [D-1:0]     det,
	input  wire logic signed [2*W:0]     cof [9],
	input  wire logic [mi3_pkg::TW-1:0]  thr,
	output logic [NW-1:0]                num [9],
	output logic [D-1:0]                 adet,
	output mi3_pkg::side_t               side [9]
);
	import mi3_pkg::*;

	logic [D-1:0]  adet_s6;
	logic          dneg_s6;
	logic [2*W:0]  cabs_s6 [9];
	logic          cneg_s6 [9];
	logic [NW-1:0] num_s7 [9];
	logic [D-1:0]  adet_s7;
	side_t         side_s7 [9];
	logic          zero;

	// absolute values
	always_ff @(posedge clk) begin
		if (en[0]) begin
			adet_s6 <= det[D-1] ? D'(-det) : D'(det);
			dneg_s6 <= det[D-1];
		end
	end

	for (genvar k = 0; k < 9; k++) begin : g_abs
		always_ff @(posedge clk) begin
			if (en[0]) begin
				cabs_s6[k] <= cof[k][2*W] ? (2*W+1)'(-cof[k]) : (2*W+1)'(cof[k]);
				cneg_s6[k] <= cof[k][2*W];
			end
		end
	end

	// zero determinant is always singular, as is one below the threshold
	assign zero = (adet_s6 == '0) || (adet_s6 < D'(thr));

	// inverse element (i,j) takes cofactor (j,i); numerator rounds to nearest
	for (genvar e = 0; e < 9; e++) begin : g_num
		localparam int C = (e % 3) * 3 + e / 3;
		always_ff @(posedge clk) begin
			if (en[1]) begin
				num_s7[e]       <= (NW'(cabs_s6[C]) << (2*F)) + NW'(adet_s6 >> 1);
				side_s7[e].neg  <= cneg_s6[C] ^ dneg_s6;
				side_s7[e].zero <= zero;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			adet_s7 <= adet_s6;
		end
	end

	assign num  = num_s7;
	assign adet = adet_s7;
	assign side = side_s7;
endmodule
`default_nettype wire

/* rtl/mi3_div.sv */
`default_nettype none
// One divider lane: overflow precheck, W+1 restoring steps, saturation
module mi3_div #(
	parameter int W  = 32,
	parameter int D  = 3*W+3,
	parameter int NW = 3*W+3
) (
	input  wire logic            clk,
	input  wire logic [W+2:0]    en,
	input  wire logic [NW-1:0]   num,
	input  wire logic [D-1:0]    adet,
	input  mi3_pkg::side_t       side,
	output logic signed [W-1:0]  res,
	output logic                 zero
);
	import mi3_pkg::*;

	localparam int RW = D + 1;
	localparam int XW = (NW > D + W + 1) ? NW : D + W + 1;

	logic [RW-1:0] rem_s  [W+2];
	logic [W:0]    nb_s   [W+2];
	logic [W:0]    q_s    [W+2];
	logic [D-1:0]  adet_s [W+2];
	side_t         side_s [W+2];
	logic          ovf_s  [W+2];
	logic signed [W-1:0] res_q;
	logic                zero_q;

	// quotient of 2^(W+1) or more saturates unless the element is singular
	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_s[0]  <= RW'(num >> (W + 1));
			nb_s[0]   <= num[W:0];
			q_s[0]    <= '0;
			adet_s[0] <= adet;
			side_s[0] <= side;
			ovf_s[0]  <= XW'(num) >= (XW'(adet) << (W + 1));
		end
	end

	// one quotient bit per stage
	for (genvar k = 1; k <= W + 1; k++) begin : g_step
		logic [RW-1:0] t;
		logic          ge;
		assign t  = {rem_s[k-1][RW-2:0], nb_s[k-1][W]};
		assign ge = t >= RW'(adet_s[k-1]);
		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k]  <= ge ? t - RW'(adet_s[k-1]) : t;
				nb_s[k]   <= nb_s[k-1] << 1;
				q_s[k]    <= {q_s[k-1][W-1:0], ge};
				adet_s[k] <= adet_s[k-1];
				side_s[k] <= side_s[k-1];
				ovf_s[k]  <= ovf_s[k-1];
			end
		end
	end

	// sign, clamp to the field range, zero when singular
	logic [W:0] q;
	logic       sat_p;
	logic       sat_n;
	assign q     = q_s[W+1];
	assign sat_p = ovf_s[W+1] | q[W] | q[W-1];
	assign sat_n = ovf_s[W+1] | q[W] | (q[W-1] & (|q[W-2:0]));

	always_ff @(posedge clk) begin
		if (en[W+2]) begin
			zero_q <= side_s[W+1].zero;
			if (side_s[W+1].zero) begin
				res_q <= '0;
			end else if (!side_s[W+1].neg) begin
				res_q <= sat_p ? $signed({1'b0, {(W-1){1'b1}}}) : $signed(q[W-1:0]);
			end else begin
				res_q <= sat_n ? $signed({1'b1, {(W-1){1'b0}}}) : $signed(-q[W-1:0]);
			end
		end
	end

	assign res  = res_q;
	assign zero = zero_q;
endmodule
`default_nettype wire

/* rtl/matrix_inverse_3x3_top.sv */
`default_nettype none
// Channel | Dir | Payload
// mat     | in  | m_r0c0 .. m_r2c2, signed Q(W-F).F
// inv     | out | inv_r0c0 .. inv_r2c2 (saturated), singular
// cfg     | in  | singular_threshold, 32 bit, units of 2^-3F
//
// The pipeline has seven arithmetic stages, then per element a precheck,
// ELEM_WIDTH+1 restoring divide steps (one quotient bit each) and the output
// register. One matrix is taken per cycle unless stalled. Reset clears valid
// bits and sets the threshold to 281. A stalled output holds its beat; empty
// stages upstream keep filling, so input stalls only when every stage is full.
module matrix_inverse_3x3_top #(
	parameter int ELEM_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mi3_mat_if.sink    mat,
	mi3_inv_if.source  inv,
	mi3_cfg_if.sink    cfg
);
	import mi3_pkg::*;

	localparam int W   = ELEM_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int D   = 3*W + 3;
	localparam int NA  = 2*W + 1 + 2*F;
	localparam int NW  = ((NA > D - 1) ? NA : D - 1) + 1;
	localparam int NST = W + 10;

	logic [TW-1:0] thr_q;
	logic [NST-1:0] v_q;
	logic [NST:0]   en;

	logic signed [W-1:0] m [9];
	logic signed [2*W:0] cof2 [9];
	logic signed [W-1:0] row0 [3];
	logic signed [D-1:0] det;
	logic signed [2*W:0] cof5 [9];
	logic [NW-1:0]       num [9];
	logic [D-1:0]        adet;
	side_t               side [9];
	logic signed [W-1:0] res [9];
	logic                zero [9];

	// threshold register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg.valid) begin
			thr_q <= cfg.singular_threshold;
		end
	end

	// stage enables: a stage loads when empty or when the next one moves
	always_comb begin
		en[NST] = inv.ready;
		for (int k = NST - 1; k >= 0; k--) begin
			en[k] = ~v_q[k] | en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= mat.valid;
			end
			for (int k = 1; k < NST; k++) begin
				if (en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	assign mat.ready = en[0];

	assign m = '{mat.m_r0c0, mat.m_r0c1, mat.m_r0c2,
		mat.m_r1c0, mat.m_r1c1, mat.m_r1c2,
		mat.m_r2c0, mat.m_r2c1, mat.m_r2c2};

	mi3_cof #(.W(W)) u_cof (
		.clk  (clk),
		.en   (en[1:0]),
		.m    (m),
		.cof  (cof2),
		.row0 (row0)
	);

	mi3_det #(.W(W), .D(D)) u_det (
		.clk    (clk),
		.en     (en[4:2]),
		.cof_in (cof2),
		.row0   (row0),
		.det    (det),
		.cof    (cof5)
	);

	mi3_prep #(.W(W), .F(F), .D(D), .NW(NW)) u_prep (
		.clk  (clk),
		.en   (en[6:5]),
		.det  (det),
		.cof  (cof5),
		.thr  (thr_q),
		.num  (num),
		.adet (adet),
		.side (side)
	);

	// nine divider lanes, one per inverse element
	for (genvar e = 0; e < 9; e++) begin : g_lane
		mi3_div #(.W(W), .D(D), .NW(NW)) u_div (
			.clk  (clk),
			.en   (en[NST-1:7]),
			.num  (num[e]),
			.adet (adet),
			.side (side[e]),
			.res  (res[e]),
			.zero (zero[e])
		);
	end

	assign inv.valid    = v_q[NST-1];
	assign inv.inv_r0c0 = res[0];
	assign inv.inv_r0c1 = res[1];
	assign inv.inv_r0c2 = res[2];
	assign inv.inv_r1c0 = res[3];
	assign inv.inv_r1c1 = res[4];
	assign inv.inv_r1c2 = res[5];
	assign inv.inv_r2c0 = res[6];
	assign inv.inv_r2c1 = res[7];
	assign inv.inv_r2c2 = res[8];
	assign inv.singular = zero[0];
endmodule
`default_nettype wire
